/* sv/idc_pkg.sv */
// ----------------------------------------------------------------------------
// idc_pkg
// Shared widths, codes, types and the key normalization function of the
// item dictionary counter.
// ----------------------------------------------------------------------------
`default_nettype none

package idc_pkg;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 64;
   localparam int BLOCK_W    = 3;
   localparam int INDEX_W    = 10;
   localparam int ID_W       = 11;
   localparam int COUNT_W    = 24;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // Request operations.
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_GROUP  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_LIMIT = 1'd1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [BLOCK_W-1:0] block;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0]     item_id;
      logic [KEY_W-1:0]    entry_key;
      logic [BLOCK_W-1:0]  entry_block;
      logic [COUNT_W-1:0]  entry_count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic               group_mode;
      logic [LIMIT_W-1:0] item_limit;
   } cfg_type;

   // A key ends at its first zero byte; later bytes and bytes past the
   // key length are cleared.
   function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k,
                                                 input int unsigned nbytes);
      logic [KEY_W-1:0] r;
      logic             alive;
      r     = '0;
      alive = 1'b1;
      for (int b = 0; b < KEY_W / 8; b++) begin
         if (alive && (b < nbytes) && (k[8*b +: 8] != 8'd0)) begin
            r[8*b +: 8] = k[8*b +: 8];
         end else begin
            alive = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/idc_ram.sv */
// ----------------------------------------------------------------------------
// idc_ram
// Simple dual-port synchronous memory: one write and one registered read
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* sv/idc_engine.sv */
// ----------------------------------------------------------------------------
// idc_engine
// Sequencer of the item dictionary: scans the entry memory one entry per
// cycle, updates counts and seen marks, appends new entries, clears marks
// and serves reads.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_engine #(
   parameter int MAX_ENTRIES = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire idc_pkg::cfg_type                 cfg,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [idc_pkg::OP_W-1:0]         req_op,
   input  wire logic [idc_pkg::KEY_W-1:0]        req_item_key,
   input  wire logic [idc_pkg::BLOCK_W-1:0]      req_block_index,
   input  wire logic [idc_pkg::INDEX_W-1:0]      req_entry_index,
   output logic                                  res_valid,
   input  wire logic                             res_ready,
   output idc_pkg::rsp_type                      res,
   output logic                                  mem_re,
   output logic [$clog2(MAX_ENTRIES)-1:0]        mem_raddr,
   output logic [$clog2(MAX_ENTRIES)-1:0]        mem_waddr,
   output logic                                  ent_we,
   output idc_pkg::entry_type                    ent_wdata,
   input  wire idc_pkg::entry_type               ent_rdata,
   output logic                                  seen_we,
   output logic                                  seen_wdata,
   input  wire logic                             seen_rdata
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int LW = (CW > idc_pkg::ID_W) ? CW : idc_pkg::ID_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_MISS  = 3'd2;
   localparam logic [2:0] S_CLEAR = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [idc_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [idc_pkg::BLOCK_W-1:0]  blk_ff, blk_in;
   logic [CW-1:0]                ptr_ff, ptr_in;
   logic [CW-1:0]                filled_ff, filled_in;
   idc_pkg::rsp_type             res_ff, res_in;

   logic [CW-1:0]                ptr_next, fill_next;
   logic [LW-1:0]                ptr_next_lw, fill_next_lw, filled_lw, idx_lw, limit_lw;
   logic [idc_pkg::ID_W-1:0]     id_ptr, id_fill;
   logic                         hit, bump, accept;
   logic [idc_pkg::COUNT_W-1:0]  count_new;

   assign ptr_next     = ptr_ff + 1'b1;
   assign fill_next    = filled_ff + 1'b1;
   assign ptr_next_lw  = LW'(ptr_next);
   assign fill_next_lw = LW'(fill_next);
   assign filled_lw    = LW'(filled_ff);
   assign idx_lw       = LW'(req_entry_index);
   assign id_ptr       = ptr_next_lw[idc_pkg::ID_W-1:0];
   assign id_fill      = fill_next_lw[idc_pkg::ID_W-1:0];
   assign limit_lw     = (LW'(cfg.item_limit) > LW'(MAX_ENTRIES)) ?
                         LW'(MAX_ENTRIES) : LW'(cfg.item_limit);

   assign hit  = (ent_rdata.block == blk_ff) && (ent_rdata.key == key_ff);
   assign bump = !(cfg.group_mode && seen_rdata);
   assign count_new = (bump && (ent_rdata.count != idc_pkg::COUNT_MAX)) ?
                      ent_rdata.count + 1'b1 : ent_rdata.count;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      blk_in     = blk_ff;
      ptr_in     = ptr_ff;
      filled_in  = filled_ff;
      res_in     = res_ff;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      mem_waddr  = ptr_ff[AW-1:0];
      ent_we     = 1'b0;
      ent_wdata  = '{key: key_ff, block: blk_ff, count: count_new};
      seen_we    = 1'b0;
      seen_wdata = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in = idc_pkg::norm_key(req_item_key, KEY_BYTES);
               blk_in = req_block_index;
               ptr_in = '0;
               res_in = '0;
               case (req_op)
                  idc_pkg::OP_LOOKUP: begin
                     if (filled_ff == '0) begin
                        state_in = S_MISS;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  idc_pkg::OP_GROUP: begin
                     state_in = (filled_ff == '0) ? S_RESP : S_CLEAR;
                  end
                  idc_pkg::OP_READ: begin
                     if (idx_lw < filled_lw) begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_lw[AW-1:0];
                        ptr_in    = idx_lw[CW-1:0];
                        state_in  = S_READ;
                     end else begin
                        res_in.status = idc_pkg::ST_RANGE;
                        state_in      = S_RESP;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               ent_we     = 1'b1;
               ent_wdata  = '{key: ent_rdata.key, block: ent_rdata.block,
                              count: count_new};
               seen_we    = cfg.group_mode;
               seen_wdata = 1'b1;
               res_in     = '{item_id: id_ptr, entry_key: ent_rdata.key,
                              entry_block: ent_rdata.block, entry_count: count_new,
                              status: idc_pkg::ST_OK};
               state_in   = S_RESP;
            end else if (ptr_next == filled_ff) begin
               state_in = S_MISS;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_next[AW-1:0];
               ptr_in    = ptr_next;
            end
         end
         S_MISS: begin
            if (filled_lw >= limit_lw) begin
               res_in        = '0;
               res_in.status = idc_pkg::ST_FULL;
            end else begin
               mem_waddr  = filled_ff[AW-1:0];
               ent_we     = 1'b1;
               ent_wdata  = '{key: key_ff, block: blk_ff, count: idc_pkg::COUNT_W'(1)};
               seen_we    = 1'b1;
               seen_wdata = cfg.group_mode;
               filled_in  = fill_next;
               res_in     = '{item_id: id_fill, entry_key: key_ff, entry_block: blk_ff,
                              entry_count: idc_pkg::COUNT_W'(1),
                              status: idc_pkg::ST_OK};
            end
            state_in = S_RESP;
         end
         S_CLEAR: begin
            seen_we = 1'b1;
            if (ptr_next == filled_ff) begin
               state_in = S_RESP;
            end else begin
               ptr_in = ptr_next;
            end
         end
         S_READ: begin
            res_in   = '{item_id: id_ptr, entry_key: ent_rdata.key,
                         entry_block: ent_rdata.block, entry_count: ent_rdata.count,
                         status: idc_pkg::ST_OK};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         filled_ff <= '0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
      end
      key_ff <= key_in;
      blk_ff <= blk_in;
      ptr_ff <= ptr_in;
      res_ff <= res_in;
   end

endmodule

`default_nettype wire

/* sv/item_dictionary_counter.sv */
// ----------------------------------------------------------------------------
// item_dictionary_counter
// Dictionary of distinct (block, key) items in insertion order with
// saturating occurrence counts and per-group seen marks.
// ----------------------------------------------------------------------------
// Lookups scan the filled entries in order, one entry read per cycle, until a
// hit or the end of the filled entries; a new group clears one seen mark per
// cycle. Only one request is in flight; the next can be accepted in the cycle
// after the response moves into the output register. Reset empties the table.
`default_nettype none

module item_dictionary_counter #(
   parameter int MAX_ENTRIES = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [idc_pkg::OP_W-1:0]           req_op,
   input  wire logic [idc_pkg::KEY_W-1:0]          req_item_key,
   input  wire logic [idc_pkg::BLOCK_W-1:0]        req_block_index,
   input  wire logic [idc_pkg::INDEX_W-1:0]        req_entry_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [idc_pkg::ID_W-1:0]                rsp_item_id,
   output logic [idc_pkg::KEY_W-1:0]               rsp_entry_key,
   output logic [idc_pkg::BLOCK_W-1:0]             rsp_entry_block,
   output logic [idc_pkg::COUNT_W-1:0]             rsp_entry_count,
   output logic [idc_pkg::STATUS_W-1:0]            rsp_status,
   input  wire logic                               csr_we,
   input  wire logic [idc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [idc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(MAX_ENTRIES);

   idc_pkg::cfg_type   cfg_ff, cfg_in;
   idc_pkg::rsp_type   out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               res_valid, res_ready;
   idc_pkg::rsp_type   res;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr, mem_waddr;
   logic               ent_we, seen_we, seen_wdata, seen_rdata;
   idc_pkg::entry_type ent_wdata, ent_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            idc_pkg::CSR_GROUP_MODE: cfg_in.group_mode = csr_wdata[0];
            idc_pkg::CSR_ITEM_LIMIT: cfg_in.item_limit = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // The output register frees the engine as soon as a response is parked.
   assign res_ready    = !out_valid_ff || rsp_ready;
   assign out_valid_in = res_valid || (out_valid_ff && !rsp_ready);
   assign out_in       = (res_valid && res_ready) ? res : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{group_mode: 1'b0, item_limit: idc_pkg::LIMIT_RESET};
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   idc_engine #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BYTES   (KEY_BYTES)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_item_key    (req_item_key),
      .req_block_index (req_block_index),
      .req_entry_index (req_entry_index),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res),
      .mem_re          (mem_re),
      .mem_raddr       (mem_raddr),
      .mem_waddr       (mem_waddr),
      .ent_we          (ent_we),
      .ent_wdata       (ent_wdata),
      .ent_rdata       (ent_rdata),
      .seen_we         (seen_we),
      .seen_wdata      (seen_wdata),
      .seen_rdata      (seen_rdata)
   );

   idc_ram #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH ($bits(idc_pkg::entry_type))
   ) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (mem_waddr),
      .wdata (ent_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (ent_rdata)
   );

   idc_ram #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (1)
   ) u_seen_ram (
      .clock (clock),
      .we    (seen_we),
      .waddr (mem_waddr),
      .wdata (seen_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (seen_rdata)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_item_id     = out_ff.item_id;
   assign rsp_entry_key   = out_ff.entry_key;
   assign rsp_entry_block = out_ff.entry_block;
   assign rsp_entry_count = out_ff.entry_count;
   assign rsp_status      = out_ff.status;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_full_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == idc_pkg::ST_FULL) |->
         (rsp_item_id == '0 && rsp_entry_count == '0))
      else $error("table-full response carries an entry");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while one is in flight");

   a_ok_lookup_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == idc_pkg::ST_OK && rsp_item_id != '0) |->
         rsp_entry_count != '0)
      else $error("entry returned with zero count");

endmodule

`default_nettype wire

/* tb/idc_response_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idc_response_checker
// Watches the request, response and register ports of the item dictionary
// counter, keeps its own copy of the dictionary, predicts every response and
// compares each field of the responses in order.
// ----------------------------------------------------------------------------

module idc_response_checker #(
   parameter int MAX_ENTRIES = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [idc_pkg::OP_W-1:0]         req_op,
   input  logic [idc_pkg::KEY_W-1:0]        req_item_key,
   input  logic [idc_pkg::BLOCK_W-1:0]      req_block_index,
   input  logic [idc_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [idc_pkg::ID_W-1:0]         rsp_item_id,
   input  logic [idc_pkg::KEY_W-1:0]        rsp_entry_key,
   input  logic [idc_pkg::BLOCK_W-1:0]      rsp_entry_block,
   input  logic [idc_pkg::COUNT_W-1:0]      rsp_entry_count,
   input  logic [idc_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_we,
   input  logic [idc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [idc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               error_count,
   output int                               pending_count,
   output int                               filled_count
);

   logic [idc_pkg::KEY_W-1:0]   dict_key   [MAX_ENTRIES];
   logic [idc_pkg::BLOCK_W-1:0] dict_block [MAX_ENTRIES];
   logic [idc_pkg::COUNT_W-1:0] dict_count [MAX_ENTRIES];
   logic                        seen_mark  [MAX_ENTRIES];
   int                          fill_level;
   logic                        cfg_group_mode;
   logic [idc_pkg::LIMIT_W-1:0] cfg_item_limit;
   idc_pkg::rsp_type            predicted_responses [$];
   int                          mismatch_total = 0;

   // A key is a string: it stops at its first zero byte.
   function automatic logic [idc_pkg::KEY_W-1:0] trim_key(
         input logic [idc_pkg::KEY_W-1:0] raw);
      logic [idc_pkg::KEY_W-1:0] kept;
      int                        b;
      kept = '0;
      b    = 0;
      while (b < KEY_BYTES && b < idc_pkg::KEY_W / 8 && raw[8*b +: 8] != 8'h00) begin
         kept[8*b +: 8] = raw[8*b +: 8];
         b++;
      end
      return kept;
   endfunction

   // Applies one request to the local dictionary and returns its response.
   function automatic idc_pkg::rsp_type dictionary_response(
         input logic [idc_pkg::OP_W-1:0]    op,
         input logic [idc_pkg::KEY_W-1:0]   raw_key,
         input logic [idc_pkg::BLOCK_W-1:0] blk,
         input logic [idc_pkg::INDEX_W-1:0] idx);
      idc_pkg::rsp_type          r;
      logic [idc_pkg::KEY_W-1:0] key;
      int                        hit;
      int                        cap;
      r   = '0;
      key = trim_key(raw_key);
      case (op)
         idc_pkg::OP_LOOKUP: begin
            hit = -1;
            for (int i = 0; i < fill_level; i++) begin
               if (hit < 0 && dict_block[i] == blk && dict_key[i] == key) begin
                  hit = i;
               end
            end
            cap = (cfg_item_limit < MAX_ENTRIES) ? int'(cfg_item_limit) : MAX_ENTRIES;
            if (hit >= 0) begin
               // In group mode an entry is counted once until the next group.
               if ((!cfg_group_mode || !seen_mark[hit]) &&
                   dict_count[hit] != idc_pkg::COUNT_MAX) begin
                  dict_count[hit] = dict_count[hit] + 1'b1;
               end
               if (cfg_group_mode) begin
                  seen_mark[hit] = 1'b1;
               end
               r.item_id     = idc_pkg::ID_W'(hit + 1);
               r.entry_key   = dict_key[hit];
               r.entry_block = dict_block[hit];
               r.entry_count = dict_count[hit];
            end else if (fill_level >= cap) begin
               r.status = idc_pkg::ST_FULL;
            end else begin
               dict_key[fill_level]   = key;
               dict_block[fill_level] = blk;
               dict_count[fill_level] = idc_pkg::COUNT_W'(1);
               seen_mark[fill_level]  = cfg_group_mode;
               fill_level++;
               r.item_id     = idc_pkg::ID_W'(fill_level);
               r.entry_key   = key;
               r.entry_block = blk;
               r.entry_count = idc_pkg::COUNT_W'(1);
            end
         end
         idc_pkg::OP_GROUP: begin
            foreach (seen_mark[i]) begin
               seen_mark[i] = 1'b0;
            end
         end
         idc_pkg::OP_READ: begin
            if (idx < fill_level) begin
               r.item_id     = idc_pkg::ID_W'(idx + 1);
               r.entry_key   = dict_key[idx];
               r.entry_block = dict_block[idx];
               r.entry_count = dict_count[idx];
            end else begin
               r.status = idc_pkg::ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void compare_field(input string name,
                                         input logic [idc_pkg::KEY_W-1:0] want,
                                         input logic [idc_pkg::KEY_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_total++;
      end
   endfunction

   always @(posedge clock) begin
      idc_pkg::rsp_type want;
      if (reset) begin
         predicted_responses.delete();
         fill_level     = 0;
         cfg_group_mode = 1'b0;
         cfg_item_limit = idc_pkg::LIMIT_RESET;
         foreach (seen_mark[i]) begin
            seen_mark[i] = 1'b0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               idc_pkg::CSR_GROUP_MODE: cfg_group_mode = csr_wdata[0];
               idc_pkg::CSR_ITEM_LIMIT: cfg_item_limit = csr_wdata[idc_pkg::LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               $display({"%0t: response with no request outstanding, expected none, ",
                         "actual id %0d status %0d"}, $time, rsp_item_id, rsp_status);
               mismatch_total++;
            end else begin
               want = predicted_responses.pop_front();
               compare_field("item_id", idc_pkg::KEY_W'(want.item_id),
                             idc_pkg::KEY_W'(rsp_item_id));
               compare_field("entry_key", want.entry_key, rsp_entry_key);
               compare_field("entry_block", idc_pkg::KEY_W'(want.entry_block),
                             idc_pkg::KEY_W'(rsp_entry_block));
               compare_field("entry_count", idc_pkg::KEY_W'(want.entry_count),
                             idc_pkg::KEY_W'(rsp_entry_count));
               compare_field("status", idc_pkg::KEY_W'(want.status),
                             idc_pkg::KEY_W'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            predicted_responses.push_back(dictionary_response(req_op, req_item_key,
                                                              req_block_index,
                                                              req_entry_index));
         end
      end
      error_count   <= mismatch_total;
      pending_count <= predicted_responses.size();
      filled_count  <= fill_level;
   end

endmodule

/* tb/item_dictionary_counter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// item_dictionary_counter_test
// Drives directed and random requests into the item dictionary counter under
// several register settings and idle patterns; a checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------

module item_dictionary_counter_test;

   localparam int SEGMENT_ITEMS = 93;
   localparam int POOL_SIZE     = 20;
   localparam int STALL_LIMIT   = 8000;
   localparam int DRAIN_CYCLES  = 16;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [idc_pkg::OP_W-1:0]       req_op;
   logic [idc_pkg::KEY_W-1:0]      req_item_key;
   logic [idc_pkg::BLOCK_W-1:0]    req_block_index;
   logic [idc_pkg::INDEX_W-1:0]    req_entry_index;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [idc_pkg::ID_W-1:0]       rsp_item_id;
   logic [idc_pkg::KEY_W-1:0]      rsp_entry_key;
   logic [idc_pkg::BLOCK_W-1:0]    rsp_entry_block;
   logic [idc_pkg::COUNT_W-1:0]    rsp_entry_count;
   logic [idc_pkg::STATUS_W-1:0]   rsp_status;
   logic                           csr_we;
   logic [idc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [idc_pkg::CSR_DATA_W-1:0] csr_wdata;

   int                             req_idle_pct  = 0;
   int                             rsp_stall_pct = 0;
   int                             quiet_cycles  = 0;
   int                             error_count;
   int                             pending_count;
   int                             filled_count;
   logic [idc_pkg::KEY_W-1:0]      key_pool [POOL_SIZE];
   int                             key_len  [POOL_SIZE];

   item_dictionary_counter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_item_key    (req_item_key),
      .req_block_index (req_block_index),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item_id     (rsp_item_id),
      .rsp_entry_key   (rsp_entry_key),
      .rsp_entry_block (rsp_entry_block),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   idc_response_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_item_key    (req_item_key),
      .req_block_index (req_block_index),
      .req_entry_index (req_entry_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item_id     (rsp_item_id),
      .rsp_entry_key   (rsp_entry_key),
      .rsp_entry_block (rsp_entry_block),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .filled_count    (filled_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // The longest correct wait is a full table scan plus a few stalls.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Valid is only lowered when the sender actually idles, so back-to-back
   // requests never see a low and a high in the same step.
   task automatic send_request(input logic [idc_pkg::OP_W-1:0]    op,
                               input logic [idc_pkg::KEY_W-1:0]   key,
                               input logic [idc_pkg::BLOCK_W-1:0] blk,
                               input logic [idc_pkg::INDEX_W-1:0] idx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_item_key    <= key;
      req_block_index <= blk;
      req_entry_index <= idx;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_config(input logic gm, input logic [idc_pkg::LIMIT_W-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= idc_pkg::CSR_GROUP_MODE;
      csr_wdata <= idc_pkg::CSR_DATA_W'(gm);
      @(posedge clock);
      csr_index <= idc_pkg::CSR_ITEM_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_item();
      int                          pick;
      int                          slot;
      logic [idc_pkg::KEY_W-1:0]   key;
      logic [idc_pkg::BLOCK_W-1:0] blk;
      logic [idc_pkg::INDEX_W-1:0] idx;
      pick = $urandom_range(99);
      key  = {$urandom, $urandom};
      blk  = ($urandom_range(4) == 0) ? idc_pkg::BLOCK_W'($urandom_range(7)) :
                                        idc_pkg::BLOCK_W'($urandom_range(3));
      idx  = idc_pkg::INDEX_W'($urandom_range(1023));
      if (pick < 70) begin
         // Mostly keys from a small pool so that lookups hit stored entries.
         if ($urandom_range(6) != 0) begin
            slot = $urandom_range(POOL_SIZE - 1);
            key  = key_pool[slot];
            if (key_len[slot] < 7 && $urandom_range(1) == 1) begin
               key = key | ({$urandom, $urandom} << (8 * (key_len[slot] + 1)));
            end
         end
         send_request(idc_pkg::OP_LOOKUP, key, blk, idx);
      end else if (pick < 78) begin
         send_request(idc_pkg::OP_GROUP, key, blk, idx);
      end else begin
         if (filled_count > 0 && $urandom_range(4) != 0) begin
            idx = idc_pkg::INDEX_W'($urandom_range(filled_count - 1));
         end
         send_request(idc_pkg::OP_READ, key, blk, idx);
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= idc_pkg::OP_LOOKUP;
      req_item_key    <= '0;
      req_block_index <= '0;
      req_entry_index <= '0;
      csr_we          <= 1'b0;
      csr_index       <= idc_pkg::CSR_GROUP_MODE;
      csr_wdata       <= '0;
      for (int s = 0; s < POOL_SIZE; s++) begin
         key_len[s]  = $urandom_range(8, 1);
         key_pool[s] = '0;
         for (int b = 0; b < key_len[s]; b++) begin
            key_pool[s][8*b +: 8] = 8'($urandom_range(255, 1));
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A limit of one: one entry fits, the next new key reports full, and
      // garbage after a zero byte still finds the stored key.
      write_config(1'b0, idc_pkg::LIMIT_W'(1));
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 3'd0, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 10'd1023);
      send_request(idc_pkg::OP_LOOKUP, 64'hDEAD_BEEF_0000_0041, 3'd0, 10'd0);
      wait_idle();
      write_config(1'b0, idc_pkg::LIMIT_RESET);
      send_request(idc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0000, 3'd0, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, 3'd7, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 3'd1, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 10'd0);
      send_request(idc_pkg::OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 10'd0);
      send_request(idc_pkg::OP_READ, 64'h0, 3'd0, 10'd1023);
      send_request(idc_pkg::OP_READ, 64'h0, 3'd0, 10'd5);
      send_request(idc_pkg::OP_READ, 64'h0, 3'd0, 10'd4);
      send_request(idc_pkg::OP_GROUP, 64'h0, 3'd0, 10'd0);
      wait_idle();

      // Group mode: repeats within a group count once, a new group reopens.
      write_config(1'b1, idc_pkg::LIMIT_RESET);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 3'd0, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 3'd0, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_4242, 3'd3, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_4242, 3'd3, 10'd0);
      send_request(idc_pkg::OP_GROUP, 64'h0, 3'd0, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 3'd0, 10'd0);
      send_request(idc_pkg::OP_LOOKUP, 64'h0000_0000_0000_4242, 3'd3, 10'd0);
      send_request(idc_pkg::OP_READ, 64'h0, 3'd0, 10'd0);

      for (int seg = 0; seg < 6; seg++) begin
         wait_idle();
         case (seg)
            0: write_config(1'b0, idc_pkg::LIMIT_RESET);
            1: write_config(1'b1, idc_pkg::LIMIT_RESET);
            2: write_config(1'b1, idc_pkg::LIMIT_W'(filled_count + 6));
            3: write_config(1'b0, idc_pkg::LIMIT_W'(filled_count + 3));
            default: write_config(1'($urandom_range(1)), idc_pkg::LIMIT_RESET);
         endcase
         req_idle_pct  = (seg < 2) ? 17 : ((seg < 4) ? 51 : 0);
         rsp_stall_pct = (seg < 2) ? 51 : ((seg < 4) ? 17 : 0);
         repeat (SEGMENT_ITEMS) send_random_item();
      end

      wait_idle();
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
